FILE: hdl/http_byte_range_parser_core_defines.svh
// Assertion macros shared by the byte range parser modules.
`ifndef HTTP_BYTE_RANGE_PARSER_CORE_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define HBRP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define HBRP_NEVER(lbl, clk, rstn, cond, msg) \
    `HBRP_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define HBRP_ASSERT(lbl, clk, rstn, prop, msg)
`define HBRP_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: hdl/hbrp_pkg.sv
// Shared constants, types and the unit prefix table of the byte range parser.
package hbrp_pkg;

    localparam int unsigned MAX_RANGES_DEF = 16;
    localparam logic [4:0]  LIMIT_RESET    = 5'd16;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNIT     = 3'd1;
    localparam logic [2:0] ST_NODASH   = 3'd2;
    localparam logic [2:0] ST_ORDER    = 3'd3;
    localparam logic [2:0] ST_SEP      = 3'd4;
    localparam logic [2:0] ST_LIMIT    = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [2:0] PREFIX_LEN = 3'd6;

    // one closed range headed for the range store
    typedef struct packed {
        logic        en;
        logic [63:0] range_end;
        logic [63:0] range_start;
    } wr_req_t;

    // summary of a header handed over on its final word
    typedef struct packed {
        logic       fire;
        logic       empty;
        logic [2:0] status;
    } fin_req_t;

    // the unit prefix "bytes="
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/hbrp_parse.sv
// Character parser: prefix match, decimal accumulation and range closing.
`include "http_byte_range_parser_core_defines.svh"

module hbrp_parse #(
    parameter int unsigned MAX_RANGES = hbrp_pkg::MAX_RANGES_DEF,
    parameter int unsigned CW = $clog2(MAX_RANGES + 1),
    parameter int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               has_char,
    input  logic [7:0]         char_code,
    input  logic               end_of_header,
    input  logic [4:0]         range_limit,
    output hbrp_pkg::wr_req_t  wr,
    output logic [AW-1:0]      wr_addr,
    output hbrp_pkg::fin_req_t fin,
    output logic [CW-1:0]      fin_total
);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_BEGIN  = 3'd1;
    localparam logic [2:0] PH_START  = 3'd2;
    localparam logic [2:0] PH_END    = 3'd3;
    localparam logic [2:0] PH_FAILED = 3'd4;

    localparam int unsigned CMPW = (CW > 5) ? CW : 5;
    localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_RANGES);

    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    pp_reg, pp_next;
    logic [63:0]   acc_reg, acc_next;
    logic          dp_reg, dp_next;
    logic [63:0]   hs_reg, hs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            pp_reg    <= '0;
            acc_reg   <= '0;
            dp_reg    <= 1'b0;
            hs_reg    <= '0;
            cnt_reg   <= '0;
            err_reg   <= hbrp_pkg::ST_OK;
        end else begin
            phase_reg <= phase_next;
            pp_reg    <= pp_next;
            acc_reg   <= acc_next;
            dp_reg    <= dp_next;
            hs_reg    <= hs_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        logic            is_digit;
        logic [67:0]     prod;
        logic [CMPW-1:0] lim_now;
        logic            close_char;
        logic            close_req;
        logic [63:0]     last_v;
        logic            empty;

        phase_next = phase_reg;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        dp_next    = dp_reg;
        hs_next    = hs_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        wr         = '0;
        wr_addr    = cnt_reg[AW-1:0];
        fin        = '0;
        fin_total  = '0;
        close_char = 1'b0;
        close_req  = 1'b0;
        empty      = 1'b0;

        is_digit = (char_code >= hbrp_pkg::CHAR_ZERO) && (char_code <= hbrp_pkg::CHAR_NINE);
        // acc * 10 + digit, carried wide so overflow shows in the top bits
        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
             + {64'b0, 4'(char_code - hbrp_pkg::CHAR_ZERO)};
        lim_now = (CMPW'(range_limit) > MAX_CMP) ? MAX_CMP : CMPW'(range_limit);
        last_v  = hbrp_pkg::ALL_ONES;

        if (accept) begin
            if (has_char) begin
                if (phase_reg == PH_PREFIX) begin
                    if (pp_reg < hbrp_pkg::PREFIX_LEN &&
                        char_code == hbrp_pkg::prefix_char(pp_reg)) begin
                        pp_next = pp_reg + 3'd1;
                        if (pp_next == hbrp_pkg::PREFIX_LEN) begin
                            phase_next = PH_BEGIN;
                        end
                    end else begin
                        phase_next = PH_FAILED;
                        err_next   = hbrp_pkg::ST_UNIT;
                    end
                end else if (phase_reg == PH_BEGIN && CMPW'(cnt_reg) >= lim_now) begin
                    phase_next = PH_FAILED;
                    err_next   = hbrp_pkg::ST_LIMIT;
                end else if (phase_reg == PH_BEGIN || phase_reg == PH_START) begin
                    // a new range opens with acc already cleared by the last close
                    phase_next = PH_START;
                    if (is_digit) begin
                        if (|prod[67:64]) begin
                            phase_next = PH_FAILED;
                            err_next   = hbrp_pkg::ST_OVERFLOW;
                        end else begin
                            acc_next = prod[63:0];
                            dp_next  = 1'b1;
                        end
                    end else if (char_code == hbrp_pkg::CHAR_DASH) begin
                        hs_next    = dp_reg ? acc_reg : hbrp_pkg::ALL_ONES;
                        acc_next   = '0;
                        dp_next    = 1'b0;
                        phase_next = PH_END;
                    end else begin
                        phase_next = PH_FAILED;
                        err_next   = hbrp_pkg::ST_NODASH;
                    end
                end else if (phase_reg == PH_END) begin
                    if (is_digit) begin
                        if (|prod[67:64]) begin
                            phase_next = PH_FAILED;
                            err_next   = hbrp_pkg::ST_OVERFLOW;
                        end else begin
                            acc_next = prod[63:0];
                            dp_next  = 1'b1;
                        end
                    end else begin
                        close_char = 1'b1;
                    end
                end
            end

            // at most one close per word: by a separator or by the final word
            close_req = close_char || (end_of_header && phase_next == PH_END);
            if (close_req) begin
                last_v = dp_next ? acc_next : hbrp_pkg::ALL_ONES;
                if (hs_next != hbrp_pkg::ALL_ONES && last_v < hs_next) begin
                    phase_next = PH_FAILED;
                    err_next   = hbrp_pkg::ST_ORDER;
                end else begin
                    if (CMPW'(cnt_reg) < MAX_CMP) begin
                        wr.en          = 1'b1;
                        wr.range_start = hs_next;
                        wr.range_end   = last_v;
                        cnt_next       = cnt_reg + CW'(1);
                    end
                    acc_next = '0;
                    dp_next  = 1'b0;
                    if (close_char) begin
                        if (char_code == hbrp_pkg::CHAR_COMMA) begin
                            phase_next = PH_BEGIN;
                        end else begin
                            phase_next = PH_FAILED;
                            err_next   = hbrp_pkg::ST_SEP;
                        end
                    end
                end
            end

            if (end_of_header) begin
                if (phase_next == PH_PREFIX) begin
                    err_next = hbrp_pkg::ST_UNIT;
                end else if (phase_next == PH_START) begin
                    err_next = hbrp_pkg::ST_NODASH;
                end
                empty      = (err_next != hbrp_pkg::ST_OK) || (cnt_next == '0);
                fin.fire   = 1'b1;
                fin.empty  = empty;
                fin.status = err_next;
                fin_total  = empty ? CW'(1) : cnt_next;
                // back to the reset parse state for the next header
                phase_next = PH_PREFIX;
                pp_next    = '0;
                acc_next   = '0;
                dp_next    = 1'b0;
                hs_next    = '0;
                cnt_next   = '0;
                err_next   = hbrp_pkg::ST_OK;
            end
        end
    end

    `HBRP_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CW'(MAX_RANGES), "range count beyond store depth")
    `HBRP_ASSERT(a_fail_code, aclk, aresetn, (phase_reg == PH_FAILED) == (err_reg != hbrp_pkg::ST_OK), "failed phase and error code disagree")
    `HBRP_NEVER(a_wr_addr, aclk, aresetn, wr.en && (cnt_reg >= CW'(MAX_RANGES)), "store write beyond depth")

endmodule

FILE: hdl/hbrp_store.sv
// Range store memory with the drain read pipeline and the result register.
`include "http_byte_range_parser_core_defines.svh"

module hbrp_store #(
    parameter int unsigned MAX_RANGES = hbrp_pkg::MAX_RANGES_DEF,
    parameter int unsigned CW = $clog2(MAX_RANGES + 1),
    parameter int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hbrp_pkg::wr_req_t  wr,
    input  logic [AW-1:0]      wr_addr,
    input  hbrp_pkg::fin_req_t fin,
    input  logic [CW-1:0]      fin_total,
    output logic               busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);

    logic [127:0]  mem [MAX_RANGES];
    logic [127:0]  rd_q;

    logic          busy_reg, busy_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          empty_reg, empty_next;
    logic [2:0]    status_reg, status_next;
    logic          rdv_reg, rdv_next;
    logic          rdlast_reg;
    logic          m_valid_reg, m_valid_next;
    logic [127:0]  m_data_reg;
    logic [3:0]    m_user_reg;
    logic          m_last_reg;

    logic          take_rd;
    logic          rd_en;

    assign take_rd = rdv_reg && (!m_valid_reg || m_tready);
    assign rd_en   = busy_reg && (issue_reg < total_reg) && (!rdv_reg || take_rd);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= {wr.range_end, wr.range_start};
        end
        if (rd_en) begin
            rd_q       <= mem[issue_reg[AW-1:0]];
            rdlast_reg <= (issue_reg + CW'(1)) == total_reg;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        total_next   = total_reg;
        issue_next   = issue_reg;
        empty_next   = empty_reg;
        status_next  = status_reg;
        rdv_next     = rdv_reg;
        m_valid_next = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (take_rd) begin
            m_valid_next = 1'b1;
            rdv_next     = 1'b0;
        end
        if (rd_en) begin
            rdv_next   = 1'b1;
            issue_next = issue_reg + CW'(1);
        end
        // drop busy once the final word of the run is taken
        if (m_valid_reg && m_tready && m_last_reg) begin
            busy_next = 1'b0;
        end
        if (fin.fire) begin
            busy_next   = 1'b1;
            total_next  = fin_total;
            issue_next  = '0;
            empty_next  = fin.empty;
            status_next = fin.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            total_reg   <= '0;
            issue_reg   <= '0;
            empty_reg   <= 1'b0;
            status_reg  <= hbrp_pkg::ST_OK;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            total_reg   <= total_next;
            issue_reg   <= issue_next;
            empty_reg   <= empty_next;
            status_reg  <= status_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_rd) begin
            m_last_reg <= rdlast_reg;
            if (empty_reg) begin
                m_data_reg <= '0;
                m_user_reg <= {status_reg, 1'b0};
            end else begin
                m_data_reg <= rd_q;
                m_user_reg <= {hbrp_pkg::ST_OK, 1'b1};
            end
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `HBRP_NEVER(a_wr_in_drain, aclk, aresetn, wr.en && busy_reg, "store written during drain")
    `HBRP_ASSERT(a_last_drained, aclk, aresetn, (m_valid_reg && m_last_reg) |-> (issue_reg == total_reg && !rdv_reg), "last word shown with reads pending")
    `HBRP_ASSERT(a_issue_bound, aclk, aresetn, issue_reg <= total_reg, "read index past run length")
    `HBRP_ASSERT(a_idle_quiet, aclk, aresetn, !busy_reg |-> (!m_valid_reg && !rdv_reg), "result pending while idle")

endmodule

FILE: hdl/http_byte_range_parser_core.sv
// Top level of the HTTP Range header byte range parser.
// The block reads an HTTP Range header value one character per input word and
// takes one word every cycle while a header is streaming in. The value must
// begin with "bytes=" and continue with comma separated start-end pairs;
// an absent start or end is reported as all ones. Each closed range is
// written into a MAX_RANGES deep range store. On the word flagged by tlast the
// block drains the run: one result word per stored range, or one word with
// range_valid low that carries the status (nonzero on any error, zero for an
// empty list). The final input word starts the drain state, each result is
// read into the store read register and then moved to the result register;
// words follow at one per cycle while m_tready stays high, paced by the single
// read port of the range store. The input side is held (s_tready low) for the
// whole drain. The store needs no clearing pass after reset: only entries
// written by the current header are read.
// range_limit may be written at any idle time and caps how many ranges are
// accepted; values above MAX_RANGES behave as MAX_RANGES.
module http_byte_range_parser_core #(
    parameter int unsigned MAX_RANGES = hbrp_pkg::MAX_RANGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: range_limit
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    // input characters
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tuser,   // [0] has_char
    input  logic         s_tlast,   // end_of_header
    // result ranges
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] range_start, [127:64] range_end
    output logic [3:0]   m_tuser,   // [0] range_valid, [3:1] status
    output logic         m_tlast    // last_result
);

    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [4:0]         range_limit_reg;
    logic               s_accept;
    logic               busy;
    hbrp_pkg::wr_req_t  wr;
    logic [AW-1:0]      wr_addr;
    hbrp_pkg::fin_req_t fin;
    logic [CW-1:0]      fin_total;

    // limit register; the port never stalls a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_limit_reg <= hbrp_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            range_limit_reg <= cfg_data;
        end
    end

    // take characters every cycle except while a run of results drains
    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;

    hbrp_parse #(
        .MAX_RANGES (MAX_RANGES),
        .CW         (CW),
        .AW         (AW)
    ) u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .has_char      (s_tuser),
        .char_code     (s_tdata),
        .end_of_header (s_tlast),
        .range_limit   (range_limit_reg),
        .wr            (wr),
        .wr_addr       (wr_addr),
        .fin           (fin),
        .fin_total     (fin_total)
    );

    hbrp_store #(
        .MAX_RANGES (MAX_RANGES),
        .CW         (CW),
        .AW         (AW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .fin       (fin),
        .fin_total (fin_total),
        .busy      (busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the HTTP Range header byte range parser.
`timescale 1ns / 100ps

module tb_top;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;

    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data = '0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;    // [7:0] char_code
    logic         s_tuser = 1'b0;  // [0] has_char
    logic         s_tlast = 1'b0;  // end_of_header

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // [63:0] range_start, [127:64] range_end
    logic [3:0]   m_tuser;         // [0] range_valid, [3:1] status
    logic         m_tlast;         // last_result

    always #2 aclk = ~aclk;

    http_byte_range_parser_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Range parser predictor: a cycle-free copy of the parse state
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        AWAIT_UNIT, AWAIT_RANGE, IN_START, IN_END, REJECTED
    } parse_phase_t;

    typedef struct {
        logic [63:0] lo_off;
        logic [63:0] hi_off;
        logic        has_range;
        logic [2:0]  status;
        logic        tail;
    } range_word_t;

    localparam logic [47:0] UNIT_TEXT = "bytes=";
    localparam int          STORE_DEPTH = hbrp_pkg::MAX_RANGES_DEF;

    logic [4:0]   limit_reg;
    int unsigned  unit_pos;
    parse_phase_t phase;
    logic [63:0]  acc;
    bit           acc_has;
    logic [63:0]  start_hold;
    logic [63:0]  store_lo [STORE_DEPTH];
    logic [63:0]  store_hi [STORE_DEPTH];
    int           n_ranges;
    logic [2:0]   err;

    range_word_t  ranges_due[$];   // result words still owed by the block
    int           results_predicted = 0;
    int           chars_sent = 0;  // words with has_char set
    int           faults = 0;

    // idle knobs, in percent
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           blank_pct = 0;

    function automatic void clear_parse();
        unit_pos   = 0;
        phase      = AWAIT_UNIT;
        acc        = '0;
        acc_has    = 1'b0;
        start_hold = '0;
        n_ranges   = 0;
        err        = hbrp_pkg::ST_OK;
    endfunction

    function automatic void reject(logic [2:0] code);
        err   = code;
        phase = REJECTED;
    endfunction

    // values above the store depth act as the store depth
    function automatic int effective_limit();
        return (limit_reg > STORE_DEPTH) ? STORE_DEPTH : int'(limit_reg);
    endfunction

    // false on overflow of the 64-bit offset
    function automatic bit push_digit(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c} - {56'd0, hbrp_pkg::CHAR_ZERO};
        if (acc > (hbrp_pkg::ALL_ONES - d) / 10)
            return 1'b0;
        acc     = acc * 10 + d;
        acc_has = 1'b1;
        return 1'b1;
    endfunction

    // order check, then store the closed range
    function automatic bit close_range();
        logic [63:0] upper;
        upper = acc_has ? acc : hbrp_pkg::ALL_ONES;
        if (start_hold != hbrp_pkg::ALL_ONES && upper < start_hold) begin
            reject(hbrp_pkg::ST_ORDER);
            return 1'b0;
        end
        if (n_ranges < STORE_DEPTH) begin
            store_lo[n_ranges] = start_hold;
            store_hi[n_ranges] = upper;
            n_ranges++;
        end
        acc     = '0;
        acc_has = 1'b0;
        return 1'b1;
    endfunction

    function automatic void start_char(logic [7:0] c);
        if (c >= hbrp_pkg::CHAR_ZERO && c <= hbrp_pkg::CHAR_NINE) begin
            if (!push_digit(c))
                reject(hbrp_pkg::ST_OVERFLOW);
        end else if (c == hbrp_pkg::CHAR_DASH) begin
            // a start of all ones reads the same as an absent start
            start_hold = acc_has ? acc : hbrp_pkg::ALL_ONES;
            acc        = '0;
            acc_has    = 1'b0;
            phase      = IN_END;
        end else begin
            reject(hbrp_pkg::ST_NODASH);
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        case (phase)
            AWAIT_UNIT: begin
                if (c == UNIT_TEXT[47 - 8 * unit_pos -: 8]) begin
                    unit_pos++;
                    if (unit_pos == hbrp_pkg::PREFIX_LEN)
                        phase = AWAIT_RANGE;
                end else begin
                    reject(hbrp_pkg::ST_UNIT);
                end
            end
            AWAIT_RANGE: begin
                if (n_ranges >= effective_limit()) begin
                    reject(hbrp_pkg::ST_LIMIT);
                end else begin
                    phase   = IN_START;
                    acc     = '0;
                    acc_has = 1'b0;
                    start_char(c);
                end
            end
            IN_START: start_char(c);
            IN_END: begin
                if (c >= hbrp_pkg::CHAR_ZERO && c <= hbrp_pkg::CHAR_NINE) begin
                    if (!push_digit(c))
                        reject(hbrp_pkg::ST_OVERFLOW);
                end else if (close_range()) begin
                    if (c == hbrp_pkg::CHAR_COMMA)
                        phase = AWAIT_RANGE;
                    else
                        reject(hbrp_pkg::ST_SEP);
                end
            end
            default: ;
        endcase
    endfunction

    // advance the predictor by one accepted word, queue the run on the final one
    function automatic void predict_word(logic has, logic [7:0] c, logic fin);
        range_word_t w;
        if (has)
            take_char(c);
        if (!fin)
            return;
        if (phase == AWAIT_UNIT)
            reject(hbrp_pkg::ST_UNIT);
        else if (phase == IN_START)
            reject(hbrp_pkg::ST_NODASH);
        else if (phase == IN_END)
            void'(close_range());
        if (err != hbrp_pkg::ST_OK || n_ranges == 0) begin
            w = '{lo_off: '0, hi_off: '0, has_range: 1'b0, status: err, tail: 1'b1};
            ranges_due.insert(ranges_due.size(), w);
            results_predicted++;
        end else begin
            for (int i = 0; i < n_ranges; i++) begin
                w = '{lo_off: store_lo[i], hi_off: store_hi[i], has_range: 1'b1,
                      status: hbrp_pkg::ST_OK, tail: (i + 1 == n_ranges)};
                ranges_due.insert(ranges_due.size(), w);
                results_predicted++;
            end
        end
        clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        range_word_t want;
        m_tready <= ($urandom_range(99) >= stall_pct);
        // sampled values are the ones the block saw at this edge
        if (aresetn && m_tvalid && m_tready) begin
            if (ranges_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: result word with nothing expected: start %h end %h user %h",
                             $realtime, m_tdata[63:0], m_tdata[127:64], m_tuser);
            end else begin
                want = ranges_due.pop_front();
                if (m_tdata[63:0] !== want.lo_off || m_tdata[127:64] !== want.hi_off ||
                    m_tuser[0] !== want.has_range || m_tuser[3:1] !== want.status ||
                    m_tlast !== want.tail) begin
                    faults++;
                    if (faults <= 10)
                        $display({"%0t: mismatch: expected start %h end %h valid %0d ",
                                  "status %0d last %0d, got start %h end %h valid %0d ",
                                  "status %0d last %0d"},
                                 $realtime, want.lo_off, want.hi_off, want.has_range,
                                 want.status, want.tail, m_tdata[63:0], m_tdata[127:64],
                                 m_tuser[0], m_tuser[3:1], m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // present one word, hold it until taken, then advance the predictor
    task automatic send_word(logic has, logic [7:0] c, logic fin);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        if (has)
            chars_sent++;
        predict_word(has, c, fin);
    endtask

    // send a header value; blank words may be mixed in, and sometimes carry the end
    task automatic send_text(string text);
        bit blank_end;
        blank_end = (text.len() == 0) || ($urandom_range(9) == 0);
        for (int i = 0; i < text.len(); i++) begin
            if ($urandom_range(99) < blank_pct)
                send_word(1'b0, 8'($urandom_range(255)), 1'b0);
            send_word(1'b1, text[i], !blank_end && (i == text.len() - 1));
        end
        if (blank_end)
            send_word(1'b0, 8'($urandom_range(255)), 1'b1);
    endtask

    // drop valid and wait for every owed result plus the output latency
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ranges_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_range_limit(logic [4:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // "bytes=0-,1-,..." with n ranges open at the end, starts counting mod 10
    function automatic string ladder(int n);
        string s;
        s = "bytes=";
        for (int k = 0; k < n; k++)
            s = $sformatf("%s%0d-%s", s, k % 10, (k + 1 < n) ? "," : "");
        return s;
    endfunction

    function automatic logic [63:0] rand_offset();
        case ($urandom_range(9))
            6, 7:    return 64'($urandom_range(99999));
            8:       return {$urandom, $urandom};
            9:       return hbrp_pkg::ALL_ONES - 64'($urandom_range(3));
            default: return 64'($urandom_range(999));
        endcase
    endfunction

    function automatic string random_header();
        string       s, a, b, alpha;
        int          n, pos;
        logic [63:0] lo, hi, t;
        logic [7:0]  ch;
        alpha = "0123456789-, x";
        // noise: random bytes, sometimes after a good prefix
        if ($urandom_range(99) < 8) begin
            s = ($urandom_range(1) == 1) ? "bytes=" : "";
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                ch = ($urandom_range(1) == 1) ? 8'($urandom_range(255))
                                              : alpha.getc($urandom_range(alpha.len() - 1));
                s = $sformatf("%s%c", s, ch);
            end
            return s;
        end
        // well-formed list with random content
        n = ($urandom_range(99) < 15) ? $urandom_range(0, effective_limit() + 1)
                                      : $urandom_range(1, 4);
        s = "bytes=";
        for (int k = 0; k < n; k++) begin
            lo = rand_offset();
            hi = lo + 64'($urandom_range(500));
            if ($urandom_range(19) == 0) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            a = ($urandom_range(9) == 0) ? "" : $sformatf("%0d", lo);
            b = ($urandom_range(9) == 0) ? "" : $sformatf("%0d", hi);
            s = {s, a, "-", b, (k + 1 < n) ? "," : ""};
        end
        if ($urandom_range(19) == 0)
            s = {s, ","};
        // break some of them
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
                0: begin
                    pos = $urandom_range(s.len() - 1);
                    ch  = ($urandom_range(1) == 1) ? 8'($urandom_range(255))
                                                   : alpha.getc($urandom_range(alpha.len() - 1));
                    s.putc(pos, ch);
                end
                1: s = s.substr(0, $urandom_range(s.len() - 1));
                default: s = {s, "99999999999999999999"};
            endcase
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // prefix must be exactly "bytes="; an empty list gives one status word
    task automatic test_unit_prefix();
        send_text("");
        send_text("byte");
        send_text("Bytes=");
        send_text("bytes=");
        send_text("bytes=-");
    endtask

    // open starts, open ends, all ones start, trailing comma, blank words
    task automatic test_range_forms();
        blank_pct = 50;
        send_text("bytes=0-4,-5,9-,");
        blank_pct = 0;
        send_text("bytes=18446744073709551615-3");
    endtask

    // nodash, order, separator and overflow codes; the first error holds until the end of the header
    task automatic test_error_codes();
        send_text("bytes=5");
        send_text("bytes=5x-9");
        send_text("bytes=9-5");
        send_text("bytes=9-5x");
        send_text("bytes=0-5;");
        send_text("bytes=18446744073709551616-");
    endtask

    // range_limit at zero, a small value, and above the store depth
    task automatic test_range_limit();
        write_range_limit(5'd0);
        send_text("bytes=7");
        write_range_limit(5'd2);
        send_text({ladder(2), ","});
        send_text(ladder(3));
        write_range_limit(5'd31);
        send_text(ladder(16));
        send_text(ladder(17));
    endtask

    // random headers until enough characters and results have gone through
    task automatic test_random_traffic(int gap, int stall, logic [4:0] lim);
        int chars0, res0;
        write_range_limit(lim);
        gap_pct   = gap;
        stall_pct = stall;
        blank_pct = 6;
        chars0    = chars_sent;
        res0      = results_predicted;
        while (chars_sent - chars0 < 12 || results_predicted - res0 < 2)
            send_text(random_header());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        limit_reg = hbrp_pkg::LIMIT_RESET;
        clear_parse();
        gap_pct   = 12;
        stall_pct = 72;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unit_prefix();
        test_range_forms();
        test_error_codes();
        test_range_limit();

        test_random_traffic(12, 72, 5'($urandom_range(1, 15)));
        test_random_traffic(72, 12, 5'd16);
        test_random_traffic(0, 0, 5'd31);

        settle();
        repeat (8) @(posedge aclk);
        if (faults == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
